// ----- rtl/ihv_pkg.sv -----
`default_nettype none

package ihv_pkg;

  // character classes seen by the back end
  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_HYPHEN,
    KIND_TEN,
    KIND_OTHER
  } kind_e;

  // one classified character as it travels through the queue
  typedef struct packed {
    kind_e      kind;
    logic [3:0] value;
    logic       last;
  } item_t;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] AsciiZero   = 8'd48;
  localparam logic [7:0] AsciiNine   = 8'd57;
  localparam logic [7:0] AsciiHyphen = 8'h2D;
  localparam logic [7:0] AsciiTen    = 8'h58;

  localparam logic [3:0] StrLength   = 4'd13;
  localparam logic [3:0] Modulus     = 4'd11;
  localparam logic [3:0] TenValue    = 4'd10;
  localparam logic [3:0] PrefixSyms  = 4'd9;
  localparam logic [2:0] HyphenTotal = 3'd3;

  localparam logic [3:0] MaxGroup0   = 4'd5;
  localparam logic [3:0] MaxGroup1   = 4'd7;
  localparam logic [3:0] MaxGroup2   = 4'd6;

  // sum of two residues below the modulus, reduced once
  function automatic logic [3:0] add_mod11(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, Modulus}) begin
      s = s - {1'b0, Modulus};
    end
    return s[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ihv_front.sv -----
`default_nettype none

module ihv_front
  import ihv_pkg::*;
(
  input  wire logic [7:0] symbol_i,
  input  wire logic       last_i,
  output item_t           item_o
);

  logic [7:0] digit_off;

  assign digit_off = symbol_i - AsciiZero;

  // sort the character into its class and numeric value
  always_comb begin
    item_o.last  = last_i;
    item_o.value = '0;
    if (symbol_i >= AsciiZero && symbol_i <= AsciiNine) begin
      item_o.kind  = KIND_DIGIT;
      item_o.value = digit_off[3:0];
    end else if (symbol_i == AsciiHyphen) begin
      item_o.kind = KIND_HYPHEN;
    end else if (symbol_i == AsciiTen) begin
      item_o.kind  = KIND_TEN;
      item_o.value = TenValue;
    end else begin
      item_o.kind = KIND_OTHER;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ihv_queue.sv -----
`default_nettype none

module ihv_queue
  import ihv_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t push_item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      pop_item_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t              slot_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ihv_back.sv -----
`default_nettype none

module ihv_back
  import ihv_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire item_t item_i,
  input  wire logic  item_vld_i,
  output logic       pop_o,
  output logic       res_vld_o,
  output logic       res_o,
  input  wire logic  res_rdy_i
);

  logic [3:0] char_cnt_q, char_cnt_d;
  logic [2:0] hyph_cnt_q, hyph_cnt_d;
  logic [3:0] grp_len_q, grp_len_d;
  logic [3:0] sym_cnt_q, sym_cnt_d;
  logic [3:0] run_q, run_d;
  logic [3:0] acc_q, acc_d;
  logic       err_q, err_d;
  logic       out_vld_q, out_vld_d;
  logic       out_res_q, out_res_d;

  logic       is_sym;
  logic       bad_grp;
  logic [3:0] addend;
  logic [3:0] run_sum;
  logic       ok;

  // a final character needs the output slot, others never wait
  assign pop_o = item_vld_i && (!item_i.last || !out_vld_q || res_rdy_i);

  assign res_vld_o = out_vld_q;
  assign res_o     = out_res_q;

  assign is_sym = (item_i.kind == KIND_DIGIT) ||
                  (item_i.kind == KIND_TEN && hyph_cnt_q == HyphenTotal);

  // group length limits checked when a hyphen closes a group
  assign bad_grp = (hyph_cnt_q == 3'd0 && (grp_len_q == '0 || grp_len_q > MaxGroup0)) ||
                   (hyph_cnt_q == 3'd1 && (grp_len_q == '0 || grp_len_q > MaxGroup1)) ||
                   (hyph_cnt_q == 3'd2 && (grp_len_q == '0 || grp_len_q > MaxGroup2));

  // weighted sum as a sum of prefix sums: symbol i gets weight 10 - i
  assign addend  = (sym_cnt_q < PrefixSyms && item_i.kind == KIND_TEN) ? '0 : item_i.value;
  assign run_sum = add_mod11(run_q, addend);

  // state update for one character
  always_comb begin
    char_cnt_d = (char_cnt_q == 4'hF) ? char_cnt_q : char_cnt_q + 1'b1;
    hyph_cnt_d = hyph_cnt_q;
    grp_len_d  = grp_len_q;
    sym_cnt_d  = sym_cnt_q;
    run_d      = run_q;
    acc_d      = acc_q;
    err_d      = err_q;
    if (is_sym) begin
      if (sym_cnt_q <= PrefixSyms) begin
        run_d = run_sum;
        acc_d = add_mod11(acc_q, run_sum);
      end
      sym_cnt_d = (sym_cnt_q == 4'hF) ? sym_cnt_q : sym_cnt_q + 1'b1;
      grp_len_d = (grp_len_q == 4'hF) ? grp_len_q : grp_len_q + 1'b1;
    end else if (item_i.kind == KIND_HYPHEN) begin
      if (bad_grp) begin
        err_d = 1'b1;
      end
      hyph_cnt_d = (hyph_cnt_q == 3'h7) ? hyph_cnt_q : hyph_cnt_q + 1'b1;
      grp_len_d  = '0;
    end else begin
      err_d = 1'b1;
    end
  end

  assign ok = !err_d && char_cnt_d == StrLength && item_i.kind != KIND_HYPHEN &&
              hyph_cnt_d == HyphenTotal && grp_len_d == 4'd1 && acc_d == '0;

  // output register
  always_comb begin
    out_vld_d = out_vld_q;
    out_res_d = out_res_q;
    if (res_rdy_i) begin
      out_vld_d = 1'b0;
    end
    if (pop_o && item_i.last) begin
      out_vld_d = 1'b1;
      out_res_d = ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_cnt_q <= '0;
      hyph_cnt_q <= '0;
      grp_len_q  <= '0;
      sym_cnt_q  <= '0;
      run_q      <= '0;
      acc_q      <= '0;
      err_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (pop_o) begin
        if (item_i.last) begin
          char_cnt_q <= '0;
          hyph_cnt_q <= '0;
          grp_len_q  <= '0;
          sym_cnt_q  <= '0;
          run_q      <= '0;
          acc_q      <= '0;
          err_q      <= 1'b0;
        end else begin
          char_cnt_q <= char_cnt_d;
          hyph_cnt_q <= hyph_cnt_d;
          grp_len_q  <= grp_len_d;
          sym_cnt_q  <= sym_cnt_d;
          run_q      <= run_d;
          acc_q      <= acc_d;
          err_q      <= err_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

endmodule

`default_nettype wire

// ----- rtl/isbn10_hyphenated_validator_core.sv -----
// a final character leaves the queue, then its result is registered in the back end
// throughput: one character per cycle while the result output is not stalled, set by the update in the back end
// a two-entry queue between classifier and back end absorbs output stalls
// reset: asynchronous active-low, clears the queue, all string state and the result valid
`default_nettype none

module isbn10_hyphenated_validator_core
  import ihv_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [0] valid_res, [7:1] zero
);

  item_t front_item;
  item_t back_item;
  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  logic  res;

  assign s_axis_tready_o = !q_full;
  assign q_push          = s_axis_tvalid_i && !q_full;

  // classify each incoming character
  ihv_front u_front (
    .symbol_i (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .item_o   (front_item)
  );

  // decoupling queue
  ihv_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (back_item),
    .empty_o     (q_empty)
  );

  // string checks and result register
  ihv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (back_item),
    .item_vld_i (!q_empty),
    .pop_o      (q_pop),
    .res_vld_o  (m_axis_tvalid_o),
    .res_o      (res),
    .res_rdy_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {7'd0, res};

endmodule

`default_nettype wire

// ----- rtl/ihv_checker.sv -----
`default_nettype none

module ihv_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       s_axis_tlast_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  // final characters accepted whose result transaction is still owed
  logic [2:0] owed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      owed_q <= owed_q + 3'(s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i)
                       - 3'(m_axis_tvalid_o && m_axis_tready_i);
    end
  end

  // no result right after reset is released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid right after reset");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // padding bits of the result stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:1] == 7'd0)
    else $error("result padding not zero");

  // a result is only shown for a final character already accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> owed_q != '0)
    else $error("result without final character");

endmodule

bind isbn10_hyphenated_validator_core ihv_checker u_ihv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
